### rtl/emc_pkg.sv
// ----------------------------------------------------------------------------
// Encoder motion estimator package
// Shared widths, constants, register indexes and result codes.
// ----------------------------------------------------------------------------
package emc_pkg;

  // Default number of fraction bits in the outputs.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Operand widths of the shared arithmetic units and the output width.
  localparam int unsigned OPB_W = 32;
  localparam int unsigned DEN_W = 64;
  localparam int unsigned OUT_W = 48;

  // pi is 3.14159, so one revolution is 314159 / 50000 radians.
  localparam logic [OPB_W-1:0] PI_NUM     = 32'd314159;
  localparam logic [OPB_W-1:0] TWO_PI_DEN = 32'd50000;
  localparam int unsigned      RADIUS_FRAC = 24;

  // Register reset values.
  localparam logic [15:0] PPR_RST    = 16'd90;
  localparam logic [31:0] RADIUS_RST = 32'd110310;
  localparam logic [31:0] TPS_RST    = 32'd1000000;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_PPR    = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_TPS    = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FIRST = 2'd1,
    ST_BADDT = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  // Saturated output value with its overflow flag.
  typedef struct packed {
    logic [OUT_W-1:0] val;
    logic             over;
  } sat_t;

endpackage

### rtl/encoder_motion_estimator.sv
// ----------------------------------------------------------------------------
// Encoder motion estimator
// Angle, angular and linear velocity and acceleration from timestamped
// encoder counts, computed by a sequencer over one multiplier and one divider.
// ----------------------------------------------------------------------------
// A first sample of a run gives its result in the cycle after transfer.
// A normal sample runs four radix-2 divisions and nine multiplies in turn;
// a bad time step ends once the angle and linear position are done.
// Throughput: one sample at a time; the input is not ready until the result
// transfer. Reset restores register defaults and clears all run state.
module encoder_motion_estimator #(
  parameter int unsigned FRAC_BITS = emc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input stream. tdata: timestamp[31:0], pulse_count[63:32].
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,
  // tuser: first_of_run[0].
  input  logic          s_axis_tuser,
  // Output stream. tdata: angle[47:0], angular_velocity[95:48],
  // angular_acceleration[143:96], linear_position[191:144],
  // linear_velocity[239:192], linear_acceleration[287:240].
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [287:0]  m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]    m_axis_tuser,
  // Configuration port.
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned NUM_W = 83 + FRAC_BITS;
  localparam int unsigned ACC_W = NUM_W + 32;
  localparam int unsigned OW    = emc_pkg::OUT_W;
  localparam int unsigned RF    = emc_pkg::RADIUS_FRAC;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DEN1  = 16'h0002,
    S_ANG   = 16'h0004,
    S_DANG  = 16'h0008,
    S_LPOS  = 16'h0010,
    S_CHK   = 16'h0020,
    S_DEN2  = 16'h0040,
    S_VNUM1 = 16'h0080,
    S_VNUM2 = 16'h0100,
    S_DVEL  = 16'h0200,
    S_LVEL  = 16'h0400,
    S_AACC  = 16'h0800,
    S_DAACC = 16'h1000,
    S_LACC  = 16'h2000,
    S_DLACC = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  // Saturation of a magnitude with a sign to the signed output range.
  function automatic emc_pkg::sat_t saturate(input logic [ACC_W-1:0] mag,
                                             input logic neg);
    emc_pkg::sat_t r;
    logic          hi_set;
    hi_set = |mag[ACC_W-1:OW];
    if (neg) begin
      r.over = hi_set | (mag[OW-1] & (|mag[OW-2:0]));
      r.val  = r.over ? {1'b1, {(OW-1){1'b0}}} : (OW'(0) - mag[OW-1:0]);
    end else begin
      r.over = hi_set | mag[OW-1];
      r.val  = r.over ? {1'b0, {(OW-1){1'b1}}} : mag[OW-1:0];
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic               launched_q, launched_d;

  // Configuration registers.
  logic [15:0]        ppr_q;
  logic [31:0]        radius_q;
  logic [31:0]        tps_q;

  // Run state.
  logic [31:0]        last_time_q;
  logic [31:0]        last_count_q;
  logic [OW-1:0]      last_av_q;
  logic [OW-1:0]      last_lv_q;
  logic               have_prev_q;

  // Working registers of one sample.
  logic [31:0]        ts_q;
  logic [31:0]        cnt_q;
  logic [31:0]        dt_q;
  logic [31:0]        den1_q;
  logic [63:0]        den2_q;
  logic [OW-1:0]      ang_q, av_q, aa_q, lp_q, lv_q, la_q;
  logic               sat_q;
  emc_pkg::status_e   status_q;

  // Shared unit hookup.
  logic               mul_start, mul_done;
  logic [NUM_W-1:0]   mul_x;
  logic [31:0]        mul_b;
  logic [ACC_W-1:0]   mul_res;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num;
  logic [63:0]        div_den;
  logic [NUM_W-1:0]   div_quo;

  // Derived operands.
  logic               s_xfer, m_xfer, cfg_wr;
  logic               is_mul, is_div;
  logic [15:0]        ppr_eff;
  logic [31:0]        cmag;
  logic [32:0]        dc;
  logic [31:0]        dmag;
  logic [OW:0]        dva, dvl;
  logic [OW-1:0]      dva_mag, dvl_mag;
  logic [ACC_W:0]     lin_sum;
  emc_pkg::sat_t      q_sat, lin_sat, acc_sat;
  logic               q_neg;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = state_q == S_OUT;
  assign m_axis_tdata  = {la_q, lv_q, lp_q, aa_q, av_q, ang_q};
  assign m_axis_tuser  = status_q;
  assign pready        = 1'b1;

  // Count and difference magnitudes.
  assign ppr_eff = (ppr_q == 16'd0) ? 16'd1 : ppr_q;
  assign cmag    = cnt_q[31] ? (32'd0 - cnt_q) : cnt_q;
  assign dc      = {cnt_q[31], cnt_q} - {last_count_q[31], last_count_q};
  assign dmag    = dc[32] ? (32'd0 - dc[31:0]) : dc[31:0];
  assign dva     = {av_q[OW-1], av_q} - {last_av_q[OW-1], last_av_q};
  assign dvl     = {lv_q[OW-1], lv_q} - {last_lv_q[OW-1], last_lv_q};
  assign dva_mag = dva[OW] ? (OW'(0) - dva[OW-1:0]) : dva[OW-1:0];
  assign dvl_mag = dvl[OW] ? (OW'(0) - dvl[OW-1:0]) : dvl[OW-1:0];

  // Radius product rounded back to the output scale.
  assign lin_sum = {1'b0, mul_res} + ((ACC_W+1)'(1) << (RF - 1));

  // Sign of the quantity being finished in the current state.
  always_comb begin
    case (state_q)
      S_LPOS:  q_neg = cnt_q[31];
      S_LVEL:  q_neg = dc[32];
      S_DAACC: q_neg = dva[OW];
      S_DLACC: q_neg = dvl[OW];
      default: q_neg = 1'b0;
    endcase
  end

  assign q_sat   = saturate(ACC_W'(div_quo), q_neg);
  assign lin_sat = saturate(ACC_W'(lin_sum[ACC_W:RF]), q_neg);
  assign acc_sat = q_sat;

  // Unit launches: once on entry to each arithmetic state.
  assign is_mul = (state_q == S_DEN1) || (state_q == S_ANG) || (state_q == S_LPOS) ||
                  (state_q == S_DEN2) || (state_q == S_VNUM1) || (state_q == S_VNUM2) ||
                  (state_q == S_LVEL) || (state_q == S_AACC) || (state_q == S_LACC);
  assign is_div = (state_q == S_DANG) || (state_q == S_DVEL) ||
                  (state_q == S_DAACC) || (state_q == S_DLACC);
  assign mul_start = is_mul && !launched_q;
  assign div_start = is_div && !launched_q;

  // Multiplier operand selection.
  always_comb begin
    case (state_q)
      S_DEN1: begin
        mul_x = NUM_W'(ppr_eff);
        mul_b = emc_pkg::TWO_PI_DEN;
      end
      S_ANG: begin
        mul_x = NUM_W'(cmag);
        mul_b = emc_pkg::PI_NUM;
      end
      S_LPOS, S_LVEL: begin
        mul_x = div_quo;
        mul_b = radius_q;
      end
      S_DEN2: begin
        mul_x = NUM_W'(den1_q);
        mul_b = dt_q;
      end
      S_VNUM1: begin
        mul_x = NUM_W'(dmag);
        mul_b = emc_pkg::PI_NUM;
      end
      S_VNUM2: begin
        mul_x = mul_res[NUM_W-1:0];
        mul_b = tps_q;
      end
      S_AACC: begin
        mul_x = NUM_W'(dva_mag);
        mul_b = tps_q;
      end
      S_LACC: begin
        mul_x = NUM_W'(dvl_mag);
        mul_b = tps_q;
      end
      default: begin
        mul_x = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider operands: the last product scaled by the fraction bits.
  assign div_num = {mul_res[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  always_comb begin
    case (state_q)
      S_DANG:  div_den = 64'(den1_q);
      S_DVEL:  div_den = den2_q;
      default: div_den = 64'(dt_q);
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          state_d = (s_axis_tuser || !have_prev_q) ? S_OUT : S_DEN1;
        end
      end
      S_DEN1:  if (mul_done) state_d = S_ANG;
      S_ANG:   if (mul_done) state_d = S_DANG;
      S_DANG:  if (div_done) state_d = S_LPOS;
      S_LPOS:  if (mul_done) state_d = S_CHK;
      S_CHK:   state_d = (ts_q <= last_time_q) ? S_OUT : S_DEN2;
      S_DEN2:  if (mul_done) state_d = S_VNUM1;
      S_VNUM1: if (mul_done) state_d = S_VNUM2;
      S_VNUM2: if (mul_done) state_d = S_DVEL;
      S_DVEL:  if (div_done) state_d = S_LVEL;
      S_LVEL:  if (mul_done) state_d = S_AACC;
      S_AACC:  if (mul_done) state_d = S_DAACC;
      S_DAACC: if (div_done) state_d = S_LACC;
      S_LACC:  if (mul_done) state_d = S_DLACC;
      S_DLACC: if (div_done) state_d = S_OUT;
      S_OUT:   if (m_xfer) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    launched_d = (state_d != state_q) ? 1'b0 : (launched_q | mul_start | div_start);
  end

  // Control state, configuration and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      launched_q   <= 1'b0;
      ppr_q        <= emc_pkg::PPR_RST;
      radius_q     <= emc_pkg::RADIUS_RST;
      tps_q        <= emc_pkg::TPS_RST;
      last_time_q  <= '0;
      last_count_q <= '0;
      last_av_q    <= '0;
      last_lv_q    <= '0;
      have_prev_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          emc_pkg::REG_PPR:    ppr_q    <= pwdata[15:0];
          emc_pkg::REG_RADIUS: radius_q <= pwdata;
          emc_pkg::REG_TPS:    tps_q    <= pwdata;
          default: ;
        endcase
      end
      if (state_q == S_IDLE && s_xfer && (s_axis_tuser || !have_prev_q)) begin
        last_time_q  <= s_axis_tdata[31:0];
        last_count_q <= s_axis_tdata[63:32];
        last_av_q    <= '0;
        last_lv_q    <= '0;
        have_prev_q  <= 1'b1;
      end
      if (state_q == S_DLACC && div_done) begin
        last_time_q  <= ts_q;
        last_count_q <= cnt_q;
        last_av_q    <= av_q;
        last_lv_q    <= lv_q;
      end
    end
  end

  // Sample datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          ts_q     <= s_axis_tdata[31:0];
          cnt_q    <= s_axis_tdata[63:32];
          ang_q    <= '0;
          av_q     <= '0;
          aa_q     <= '0;
          lp_q     <= '0;
          lv_q     <= '0;
          la_q     <= '0;
          sat_q    <= 1'b0;
          status_q <= emc_pkg::ST_FIRST;
        end
      end
      S_DEN1: begin
        if (mul_done) den1_q <= mul_res[31:0];
      end
      S_LPOS: begin
        if (mul_done) begin
          ang_q <= q_sat.val;
          lp_q  <= lin_sat.val;
          sat_q <= q_sat.over | lin_sat.over;
        end
      end
      S_CHK: begin
        dt_q     <= ts_q - last_time_q;
        status_q <= emc_pkg::ST_BADDT;
      end
      S_DEN2: begin
        if (mul_done) den2_q <= mul_res[63:0];
      end
      S_LVEL: begin
        if (mul_done) begin
          av_q  <= q_sat.val;
          lv_q  <= lin_sat.val;
          sat_q <= sat_q | q_sat.over | lin_sat.over;
        end
      end
      S_DAACC: begin
        if (div_done) begin
          aa_q  <= acc_sat.val;
          sat_q <= sat_q | acc_sat.over;
        end
      end
      S_DLACC: begin
        if (div_done) begin
          la_q     <= acc_sat.val;
          status_q <= (sat_q | acc_sat.over) ? emc_pkg::ST_SAT : emc_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      emc_pkg::REG_PPR:    prdata = {16'd0, ppr_q};
      emc_pkg::REG_RADIUS: prdata = radius_q;
      emc_pkg::REG_TPS:    prdata = tps_q;
      default:             prdata = '0;
    endcase
  end

  emc_mul #(
    .X_W   (NUM_W),
    .RES_W (ACC_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  emc_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

endmodule

### rtl/emc_mul.sv
// ----------------------------------------------------------------------------
// Shared chunked multiplier
// Multiplies a wide operand by a 32-bit operand, one 32x32 partial product
// per cycle, and accumulates the shifted partial products.
// ----------------------------------------------------------------------------
module emc_mul #(
  parameter int unsigned X_W   = 99,
  parameter int unsigned RES_W = 131
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [X_W-1:0]             x_i,
  input  logic [emc_pkg::OPB_W-1:0]  b_i,
  output logic                       done_o,
  output logic [RES_W-1:0]           res_o
);

  localparam int unsigned NCH   = (X_W + 31) / 32;
  localparam int unsigned CNT_W = $clog2(NCH + 1);
  localparam int unsigned IX_W  = $clog2(NCH);

  logic [NCH-1:0][31:0]          x_q;
  logic [emc_pkg::OPB_W-1:0]     b_q;
  logic [CNT_W-1:0]              idx_q;
  logic [IX_W-1:0]               pidx_q;
  logic                          pv_q;
  logic                          busy_q;
  logic [63:0]                   prod_q;
  logic [RES_W-1:0]              acc_q;
  logic                          issue;

  // A partial product is issued while chunks remain.
  assign issue  = busy_q && (idx_q != CNT_W'(NCH));
  assign done_o = busy_q && (idx_q == CNT_W'(NCH)) && !pv_q;
  assign res_o  = acc_q;

  // Sequencing of the chunk counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      pv_q   <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      pv_q   <= 1'b0;
    end else if (busy_q) begin
      pv_q <= issue;
      if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Partial products and accumulation.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= (NCH*32)'(x_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (issue) begin
        prod_q <= 64'(x_q[idx_q[IX_W-1:0]]) * 64'(b_q);
        pidx_q <= idx_q[IX_W-1:0];
      end
      if (pv_q) begin
        acc_q <= acc_q + (RES_W'(prod_q) << {pidx_q, 5'b00000});
      end
    end
  end

endmodule

### rtl/emc_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Radix-2 division of a wide numerator by a 64-bit denominator, one quotient
// bit per cycle, followed by rounding to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module emc_div #(
  parameter int unsigned NUM_W = 99
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [emc_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [NUM_W-1:0]           quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned DW    = emc_pkg::DEN_W;

  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             fits;
  logic             rnd;
  logic             last;

  // One restoring step and the final rounding decision.
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rnd     = rem_q >= (den_q - rem_q);
  assign last    = cnt_q == CNT_W'(NUM_W);

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Quotient and remainder datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (!last) begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_q <= {quo_q[NUM_W-2:0], fits};
      end else begin
        quo_q <= quo_q + NUM_W'(rnd);
      end
    end
  end

endmodule

### test/tb_encoder_motion_estimator.sv
// ----------------------------------------------------------------------------
// Encoder motion estimator testbench
// Streams timestamped encoder counts into the block under several register
// settings and checks every result, field by field, against a predictor of
// angle, velocity and acceleration kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_encoder_motion_estimator;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC     = emc_pkg::FRAC_BITS_DEF;
  localparam int unsigned RUN_ITEMS = 300;
  localparam longint      CYCLE_LIMIT = 8000000;
  localparam logic [127:0] SAT_POS = (128'd1 << 47) - 128'd1;
  localparam logic [127:0] SAT_NEG = 128'd1 << 47;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] count;
    logic        restart;
  } sample_t;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Block ports; the inputs are driven to known values from the start.
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // timestamp[31:0], pulse_count[63:32]
  logic         s_axis_tuser = 1'b0; // first_of_run[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;        // angle, ang vel, ang acc, lin pos, lin vel, lin acc
  logic [1:0]   m_axis_tuser;        // status[1:0]
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Register shadow and motion state of the predictor.
  logic [15:0] shadow_ppr = emc_pkg::PPR_RST;
  logic [31:0] shadow_radius = emc_pkg::RADIUS_RST;
  logic [31:0] shadow_tps = emc_pkg::TPS_RST;
  logic [31:0] prev_stamp = '0;
  longint      prev_count = 0;
  longint      prev_ang_vel = 0;
  longint      prev_lin_vel = 0;
  bit          run_open = 1'b0;

  // Stimulus and expected results.
  sample_t          pending_samples[$];
  logic [289:0]     expected_motion[$];
  int unsigned      send_idle_pct = 38;
  int unsigned      recv_idle_pct = 68;
  bit               hold_samples = 1'b0;
  int unsigned      error_count = 0;
  int unsigned      results_seen = 0;
  int unsigned      status_seen[4] = '{0, 0, 0, 0};
  longint           cycle_count = 0;

  string field_name[6] = '{"angle", "angular_velocity", "angular_acceleration",
                           "linear_position", "linear_velocity",
                           "linear_acceleration"};

  encoder_motion_estimator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Rounded division, ties away from zero.
  function automatic logic [127:0] div_nearest(logic [127:0] num, logic [63:0] den);
    logic [127:0] quo;
    logic [127:0] rem;
    quo = num / {64'd0, den};
    rem = num % {64'd0, den};
    if (rem >= {64'd0, den} - rem) quo = quo + 128'd1;
    return quo;
  endfunction

  // Applies the sign and clamps to the 48-bit signed range.
  function automatic logic [47:0] clamp48(logic [127:0] mag, bit neg, ref bit sat);
    logic [127:0] res;
    if (neg) begin
      if (mag > SAT_NEG) begin
        sat = 1'b1;
        res = SAT_NEG;
      end else begin
        res = mag;
      end
      res = -res;
    end else begin
      if (mag > SAT_POS) begin
        sat = 1'b1;
        res = SAT_POS;
      end else begin
        res = mag;
      end
    end
    return res[47:0];
  endfunction

  // Linear magnitude at the wheel radius (Q8.24), rounded.
  function automatic logic [127:0] at_radius(logic [127:0] mag);
    logic [127:0] prod;
    prod = mag * {96'd0, shadow_radius};
    prod = prod + (128'd1 << (emc_pkg::RADIUS_FRAC - 1));
    return prod >> emc_pkg::RADIUS_FRAC;
  endfunction

  function automatic longint widen48(logic [47:0] v);
    return longint'({{16{v[47]}}, v});
  endfunction

  // Backward difference of a velocity over the time step.
  function automatic logic [47:0] rate_of(longint dv, logic [63:0] dt, ref bit sat);
    bit           neg;
    logic [63:0]  mag;
    logic [127:0] num;
    neg = dv < 0;
    mag = neg ? 64'(-dv) : 64'(dv);
    num = ({64'd0, mag} * {96'd0, shadow_tps}) << FRAC;
    return clamp48(div_nearest(num, dt), neg, sat);
  endfunction

  // Works out the result of one accepted sample and updates the motion state.
  function automatic void predict_motion(sample_t smp);
    logic [47:0]       val[6];
    logic [63:0]       ppr;
    logic [63:0]       dt;
    logic [63:0]       mag;
    logic [127:0]      num;
    logic [127:0]      quo;
    longint            cnt;
    longint            delta;
    bit                neg;
    bit                sat;
    emc_pkg::status_e  st;
    for (int k = 0; k < 6; k++) val[k] = '0;
    sat = 1'b0;
    ppr = (shadow_ppr == 16'd0) ? 64'd1 : {48'd0, shadow_ppr};
    cnt = longint'($signed(smp.count));
    if (smp.restart || !run_open) begin
      prev_stamp = smp.stamp;
      prev_count = cnt;
      prev_ang_vel = 0;
      prev_lin_vel = 0;
      run_open = 1'b1;
      st = emc_pkg::ST_FIRST;
    end else begin
      neg = cnt < 0;
      mag = neg ? 64'(-cnt) : 64'(cnt);
      num = {64'd0, mag * 64'(emc_pkg::PI_NUM)} << FRAC;
      quo = div_nearest(num, 64'(emc_pkg::TWO_PI_DEN) * ppr);
      val[0] = clamp48(quo, neg, sat);
      val[3] = clamp48(at_radius(quo), neg, sat);
      if (smp.stamp <= prev_stamp) begin
        st = emc_pkg::ST_BADDT;
      end else begin
        dt = {32'd0, smp.stamp - prev_stamp};
        delta = cnt - prev_count;
        neg = delta < 0;
        mag = neg ? 64'(-delta) : 64'(delta);
        num = ({64'd0, mag * 64'(emc_pkg::PI_NUM)} * {96'd0, shadow_tps}) << FRAC;
        quo = div_nearest(num, 64'(emc_pkg::TWO_PI_DEN) * ppr * dt);
        val[1] = clamp48(quo, neg, sat);
        val[4] = clamp48(at_radius(quo), neg, sat);
        val[2] = rate_of(widen48(val[1]) - prev_ang_vel, dt, sat);
        val[5] = rate_of(widen48(val[4]) - prev_lin_vel, dt, sat);
        prev_stamp = smp.stamp;
        prev_count = cnt;
        prev_ang_vel = widen48(val[1]);
        prev_lin_vel = widen48(val[4]);
        st = sat ? emc_pkg::ST_SAT : emc_pkg::ST_OK;
      end
    end
    expected_motion.push_back({st, val[5], val[4], val[3], val[2], val[1], val[0]});
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    error_count++;
    $display("mismatch on result %0d, %s: got %h, expected %h",
             results_seen, what, got, want);
  endtask

  // Sample driver: launches queued samples and predicts each accepted one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_motion('{s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!hold_samples && pending_samples.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_samples[0].count, pending_samples[0].stamp};
          s_axis_tuser  <= pending_samples[0].restart;
          void'(pending_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stalls and comparison with the oldest expectation.
  always @(posedge clk_i) begin
    logic [289:0] want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        status_seen[m_axis_tuser]++;
        if (expected_motion.size() == 0) begin
          error_count++;
          $display("result %0d arrived with no sample waiting", results_seen);
        end else begin
          want = expected_motion.pop_front();
          for (int k = 0; k < 6; k++)
            if (m_axis_tdata[48*k +: 48] !== want[48*k +: 48])
              report_mismatch(field_name[k], m_axis_tdata[48*k +: 48], want[48*k +: 48]);
          if (m_axis_tuser !== want[289:288])
            report_mismatch("status", {46'd0, m_axis_tuser}, {46'd0, want[289:288]});
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_encoder_motion_estimator: done, errors");
      $finish;
    end
  end

  function automatic void queue_sample(logic [31:0] stamp, logic [31:0] count, bit restart);
    pending_samples.push_back('{stamp, count, restart});
  endfunction

  // Register write over the configuration port; the shadow follows at once
  // since the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      emc_pkg::REG_PPR:    shadow_ppr = value[15:0];
      emc_pkg::REG_RADIUS: shadow_radius = value;
      emc_pkg::REG_TPS:    shadow_tps = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_samples.size() == 0 && !s_axis_tvalid && expected_motion.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Random samples: mostly runs with rising timestamps and small count steps,
  // plus bad time steps, large jumps, restarts and pure noise.
  function automatic void queue_random_runs(int unsigned total);
    logic [31:0] stamp;
    logic [31:0] count;
    int unsigned pick;
    stamp = $urandom;
    count = $urandom;
    queue_sample(stamp, count, 1'b1);
    for (int unsigned n = 1; n < total; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        stamp = stamp + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << 24)
                                                      : $urandom_range(1, 2000));
        count = count + $urandom_range(0, 200) - 100;
        queue_sample(stamp, count, 1'b0);
      end else if (pick < 78) begin
        stamp = stamp + $urandom_range(1, 100);
        count = ($urandom_range(0, 1) == 0) ? count + $urandom : $urandom;
        queue_sample(stamp, count, 1'b0);
      end else if (pick < 86) begin
        queue_sample(stamp - $urandom_range(0, 3), count + $urandom_range(0, 20) - 10, 1'b0);
      end else if (pick < 94) begin
        stamp = $urandom;
        count = $urandom;
        queue_sample(stamp, count, 1'b1);
      end else begin
        queue_sample($urandom, $urandom, $urandom_range(0, 1));
      end
    end
  endfunction

  initial begin
    logic [31:0] ppr_set[6];
    logic [31:0] radius_set[6];
    logic [31:0] tps_set[6];
    ppr_set    = '{32'd1, 32'd65535, 32'd0, 32'd1024, 32'(emc_pkg::PPR_RST), 32'd360};
    radius_set = '{32'hffff_ffff, 32'd0, 32'h0100_0000, $urandom, emc_pkg::RADIUS_RST,
                   32'h0080_0000};
    tps_set    = '{32'hffff_ffff, 32'd1, 32'd1000, $urandom_range(1, 1000000),
                   emc_pkg::TPS_RST, 32'h8000_0000};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples at the reset settings: no previous sample, equal and
    // backward time steps, count and timestamp extremes, restarts.
    queue_sample(32'd100, 32'd5, 1'b0);
    queue_sample(32'd200, 32'd10, 1'b0);
    queue_sample(32'd200, 32'd12, 1'b0);
    queue_sample(32'd150, 32'd12, 1'b0);
    queue_sample(32'd1000, -32'sd20, 1'b0);
    queue_sample(32'd0, 32'h7fff_ffff, 1'b1);
    queue_sample(32'd1, 32'h8000_0000, 1'b0);
    queue_sample(32'hffff_ffff, 32'd0, 1'b0);
    queue_sample(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    queue_sample(32'd0, 32'd0, 1'b0);
    queue_sample(32'd5, 32'd0, 1'b1);
    queue_sample(32'd6, 32'd1, 1'b0);
    queue_sample(32'd7, 32'd1, 1'b0);
    queue_sample(32'd10, -32'sd1000, 1'b0);
    queue_sample(32'd11, 32'h7fff_ffff, 1'b0);
    queue_sample(32'd12, 32'h8000_0000, 1'b0);
    queue_sample(32'd13, 32'h8000_0000, 1'b1);
    queue_sample(32'hffff_fffe, 32'h7fff_ffff, 1'b0);
    wait_drained();

    // Random phases under different register settings and idling.
    for (int p = 0; p < 6; p++) begin
      write_reg(emc_pkg::REG_PPR, ppr_set[p]);
      write_reg(emc_pkg::REG_RADIUS, radius_set[p]);
      write_reg(emc_pkg::REG_TPS, tps_set[p]);
      send_idle_pct = (p < 2) ? 38 : (p < 4) ? 68 : 0;
      recv_idle_pct = (p < 2) ? 68 : (p < 4) ? 38 : 0;
      if (p == 1) begin
        // Hold the sender until the block has delivered every result.
        queue_random_runs(RUN_ITEMS / 2);
        wait (pending_samples.size() == 0 && !s_axis_tvalid);
        hold_samples = 1'b1;
        wait (expected_motion.size() == 0);
        hold_samples = 1'b0;
        queue_random_runs(RUN_ITEMS / 2);
      end else begin
        queue_random_runs(RUN_ITEMS);
      end
      wait_drained();
    end

    $display("Checked %0d results over six register settings and three idling modes.",
             results_seen);
    $display("Status mix: %0d ok, %0d first, %0d bad step, %0d saturated.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0 && expected_motion.size() == 0) begin
      $display("tb_encoder_motion_estimator: done, clean");
    end else begin
      $display("tb_encoder_motion_estimator: done, errors");
    end
    $finish;
  end

endmodule
